@@ design/sni_pkg.sv @@
package sni_pkg;

    localparam int MAX_AXES    = 8;
    localparam int NUM_TENSORS = 3;

    // pointer into the per-axis tables
    localparam int AXW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    // pointer into the per-tensor lanes
    localparam int TW  = (NUM_TENSORS > 1) ? $clog2(NUM_TENSORS) : 1;
    // rank/axis compare width: holds MAX_AXES and the 4-bit registers
    localparam int CW  = $clog2(MAX_AXES + 1);
    localparam int RW  = (CW > 4) ? CW : 4;
    // lanes that reach the three index fields
    localparam int NUM_OUT = (NUM_TENSORS < 3) ? NUM_TENSORS : 3;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_GOTO = 2'd1;
    localparam logic [1:0] OP_INC  = 2'd2;

    localparam int         CFG_IDX_W   = 1;
    localparam int         CFG_DATA_W  = 4;
    localparam logic [0:0] REG_RANK    = 1'b0;
    localparam logic [0:0] REG_TRACKED = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  axis;
        logic [1:0]  tensor_sel;
        logic        write_extent;
        logic [15:0] extent_value;
        logic [31:0] stride_value;
        logic [15:0] coord_value;
    } t_req;

    typedef struct packed {
        logic        more;
        logic [31:0] index_a;
        logic [31:0] index_b;
        logic [31:0] index_c;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch the request
        logic exec;     // first cycle of the op
        logic step;     // odometer walk, one axis
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_go;    // increment has axes to walk
        logic walk_done;  // current axis ends the walk
    } t_sts;

endpackage

@@ design/sni_ctrl.sv @@
module sni_ctrl
    import sni_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy,
    output logic o_strobe
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_WALK  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_REPLY = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_sts.walk_go ? S_WALK : S_DRAIN;
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_REPLY;
            end
            S_REPLY: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept = (r_state == S_IDLE) && start;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_cmd.step   = (r_state == S_WALK);
    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = (r_state == S_REPLY);

endmodule

@@ design/sni_dpath.sv @@
module sni_dpath
    import sni_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_req                  i_req,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output t_rsp                  o_rsp
);

    logic [3:0]   r_rank;
    logic [3:0]   r_tracked;
    t_req         r_req;
    logic [15:0]  r_ext    [MAX_AXES];
    logic [31:0]  r_stride [NUM_TENSORS][MAX_AXES];
    logic [15:0]  r_coord  [MAX_AXES];
    logic [31:0]  r_flat   [NUM_TENSORS];
    logic [31:0]  r_prod   [NUM_TENSORS];
    logic         r_prod_vld;
    logic         r_prod_sub;
    logic         r_more;
    logic [AXW-1:0] r_axis;
    logic [AXW-1:0] r_first;

    logic [AXW-1:0] ax_req;
    logic [AXW-1:0] ax_sel;
    logic [RW-1:0]  axis_w;
    logic [RW-1:0]  rank_sat;
    logic [RW-1:0]  tracked_w;
    logic [RW-1:0]  first_w;
    logic [RW-1:0]  start_sat;
    logic           axis_ok;
    logic           goto_hit;
    logic           goto_clr;
    logic           inc_ok;
    logic [15:0]    ext_rd;
    logic [15:0]    coord_rd;
    logic [16:0]    coord_nx;
    logic           fits;
    logic [15:0]    mul_m;
    logic           mul_sub;
    logic [47:0]    mul_full [NUM_TENSORS];
    logic [31:0]    flat_out [3];

    always_comb begin
        ax_req    = AXW'(r_req.axis);
        ax_sel    = i_cmd.step ? r_axis : ax_req;
        axis_w    = RW'(r_req.axis);
        tracked_w = RW'(r_tracked);
        rank_sat  = (RW'(r_rank) > RW'(MAX_AXES)) ? RW'(MAX_AXES) : RW'(r_rank);
        first_w   = rank_sat - tracked_w;
        start_sat = (axis_w > rank_sat - RW'(1)) ? rank_sat - RW'(1) : axis_w;
        axis_ok   = axis_w < RW'(MAX_AXES);
        goto_hit  = (r_req.op == OP_GOTO) && axis_ok && (axis_w < tracked_w);
        goto_clr  = (r_req.op == OP_GOTO) && (r_req.axis == 3'd0);
        inc_ok    = (rank_sat != '0) && (tracked_w <= rank_sat) && (start_sat >= first_w);

        ext_rd   = r_ext[r_axis];
        coord_rd = r_coord[r_axis];
        coord_nx = {1'b0, coord_rd} + 17'd1;
        fits     = coord_nx < {1'b0, ext_rd};

        // stride multiplier operand: coordinate on goto, 1 on carry stop,
        // extent-1 on wrap (zero extent wraps by adding the stride)
        if (i_cmd.step) begin
            if (fits || (ext_rd == 16'd0)) begin
                mul_m   = 16'd1;
                mul_sub = 1'b0;
            end else begin
                mul_m   = ext_rd - 16'd1;
                mul_sub = 1'b1;
            end
        end else begin
            mul_m   = r_req.coord_value;
            mul_sub = 1'b0;
        end

        for (int t = 0; t < NUM_TENSORS; t++) begin
            mul_full[t] = {16'd0, r_stride[t][ax_sel]} * {32'd0, mul_m};
        end

        for (int k = 0; k < 3; k++) begin
            flat_out[k] = '0;
        end
        for (int k = 0; k < NUM_OUT; k++) begin
            flat_out[k] = r_flat[k];
        end
    end

    assign o_sts.walk_go   = (r_req.op == OP_INC) && inc_ok;
    assign o_sts.walk_done = fits || (r_axis == r_first);

    assign o_rsp.more    = r_more;
    assign o_rsp.index_a = flat_out[0];
    assign o_rsp.index_b = flat_out[1];
    assign o_rsp.index_c = flat_out[2];

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank     <= '0;
            r_tracked  <= '0;
            r_prod_vld <= 1'b0;
            r_more     <= 1'b0;
            for (int a = 0; a < MAX_AXES; a++) begin
                r_coord[a] <= '0;
            end
            for (int t = 0; t < NUM_TENSORS; t++) begin
                r_flat[t] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RANK:    r_rank    <= i_cfg_data;
                    REG_TRACKED: r_tracked <= i_cfg_data;
                    default:     ;
                endcase
            end

            r_prod_vld <= (i_cmd.exec && goto_hit) || i_cmd.step;

            if (i_cmd.exec && goto_clr) begin
                for (int t = 0; t < NUM_TENSORS; t++) begin
                    r_flat[t] <= '0;
                end
            end else if (r_prod_vld) begin
                for (int t = 0; t < NUM_TENSORS; t++) begin
                    r_flat[t] <= r_prod_sub ? r_flat[t] - r_prod[t] : r_flat[t] + r_prod[t];
                end
            end

            if (i_cmd.exec) begin
                r_more <= 1'b0;
                if (goto_hit) begin
                    r_coord[ax_req] <= r_req.coord_value;
                end
            end else if (i_cmd.step) begin
                r_coord[r_axis] <= fits ? coord_nx[15:0] : 16'd0;
                if (fits) begin
                    r_more <= 1'b1;
                end
            end
        end
    end

    // request, products, tables and walk pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end

        if (i_cmd.exec || i_cmd.step) begin
            r_prod_sub <= mul_sub;
            for (int t = 0; t < NUM_TENSORS; t++) begin
                r_prod[t] <= mul_full[t][31:0];
            end
        end

        if (i_cmd.exec) begin
            r_axis  <= AXW'(start_sat);
            r_first <= AXW'(first_w);
            if ((r_req.op == OP_LOAD) && axis_ok) begin
                if (r_req.write_extent) begin
                    r_ext[ax_req] <= r_req.extent_value;
                end else if (RW'(r_req.tensor_sel) < RW'(NUM_TENSORS)) begin
                    r_stride[TW'(r_req.tensor_sel)][ax_req] <= r_req.stride_value;
                end
            end
        end else if (i_cmd.step && !fits) begin
            r_axis <= r_axis - AXW'(1);
        end
    end

endmodule

@@ design/strided_nd_index_iterator.sv @@
// Channel    Direction  Ports                           Transfer
// request    in         start, busy, i_req              start && !busy
// result     out        o_strobe, o_rsp                 o_strobe, one cycle
// config     in         i_cfg_we, i_cfg_idx, i_cfg_data i_cfg_we
//
// Load, goto and unused op: accept, then the EXEC and DRAIN states, strobe in REPLY.
// Increment: as above, with WALK between EXEC and DRAIN when it has axes to walk.
// The walk handles one axis per cycle through the per-tensor stride multipliers.
// Reset is synchronous; coordinates and flat indices clear, the extent and
// stride tables hold whatever was there until written.
// busy stays high until the cycle after the strobe; results cannot be stalled.
module strided_nd_index_iterator
    import sni_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_req                  i_req,
    output logic                  busy,
    output logic                  o_strobe,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    sni_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    sni_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_rsp      (o_rsp)
    );

endmodule

@@ design/sni_chk.sv @@
module sni_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but busy not raised");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && !o_strobe |=> busy)
        else $error("busy dropped before result");

    a_strobe_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy && !o_strobe)
        else $error("request not closed after result");

endmodule

bind strided_nd_index_iterator sni_chk u_sni_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe)
);
